@@ rtl/srt_pkg.sv @@
// ----------------------------------------------------------------------------
// srt_pkg: shared definitions for the shortest-remaining-time scheduler
// Sizes, operation codes, the slot table entry, controller states and helpers.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam int SLOTS      = 16;
  localparam int CLOCK_BITS = 16;
  localparam int BURST_BITS = 12;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SPAN_W = (CLOCK_BITS > BURST_BITS) ? CLOCK_BITS : BURST_BITS;

  localparam logic [CLOCK_BITS-1:0] CLOCK_MAX = '1;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [CLOCK_BITS-1:0] arrival;
    logic [BURST_BITS-1:0] burst;
    logic [BURST_BITS-1:0] remaining;
  } slot_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_UPDATE,
    S_SPAN,
    S_RESULT
  } state_t;

  function automatic logic [15:0] sat16(input logic [31:0] v);
    logic [15:0] r;
    r = (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
    return r;
  endfunction

endpackage

@@ rtl/shortest_remaining_time_scheduler.sv @@
// ----------------------------------------------------------------------------
// shortest_remaining_time_scheduler: preemptive SRTF scheduler over a slot table
// A tick scans the slot memory one entry per cycle through its single read
// port, then passes scan-end, update and span; other beats go from idle
// straight to the result state. A new beat is taken only back in idle.
// Reset clears the clock and the valid and done flags; no memory clearing pass.
// ----------------------------------------------------------------------------
module shortest_remaining_time_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [3:0]  slot,
  input  logic [15:0] arrival,
  input  logic [11:0] burst,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        ran,
  output logic [3:0]  run_slot,
  output logic        finished,
  output logic [15:0] wait_span,
  output logic [15:0] turnaround,
  output logic        all_finished,
  output logic [15:0] elapsed
);

  localparam int SW = srt_pkg::SLOT_W;
  localparam int CB = srt_pkg::CLOCK_BITS;
  localparam int BB = srt_pkg::BURST_BITS;
  localparam int PW = srt_pkg::SPAN_W;

  srt_pkg::state_t state, state_next;

  srt_pkg::slot_entry_t slot_mem [srt_pkg::SLOTS];
  srt_pkg::slot_entry_t rd_data;
  srt_pkg::slot_entry_t mem_wdata;
  logic [SW-1:0]        mem_waddr;
  logic                 mem_we;
  logic                 mem_re;

  logic [srt_pkg::SLOTS-1:0] slot_valid;
  logic [srt_pkg::SLOTS-1:0] slot_done;
  logic [CB-1:0]             clock_now;

  logic [1:0]    op_q;
  logic [SW-1:0] scan_cnt;
  logic          eval_valid;
  logic [SW-1:0] eval_idx;
  logic          best_found;
  logic [SW-1:0] best_idx;
  logic [CB-1:0] best_arr;
  logic [BB-1:0] best_burst;
  logic [BB-1:0] best_rem;
  logic          fin_q;
  logic [CB-1:0] span_q;

  logic          accept;
  logic          load_hit;
  logic [SW-1:0] load_idx;
  logic [BB-1:0] burst_in;
  logic          eval_take;
  logic [BB-1:0] rem_dec;
  logic [CB-1:0] clock_inc;
  logic          out_load;
  logic [PW-1:0] span_ext;
  logic [PW-1:0] burst_ext;
  logic [15:0]   wait_calc;
  logic          res_ran;

  assign accept    = in_valid && in_ready;
  assign load_idx  = SW'(slot);
  assign burst_in  = BB'(burst);
  assign load_hit  = accept && (op == srt_pkg::OP_LOAD) && (32'(slot) < srt_pkg::SLOTS);
  assign eval_take = eval_valid && slot_valid[eval_idx] && !slot_done[eval_idx] &&
                     (rd_data.arrival <= clock_now) &&
                     (!best_found || (rd_data.remaining < best_rem));
  assign rem_dec   = (best_rem != '0) ? best_rem - BB'(1) : '0;
  assign clock_inc = (clock_now != srt_pkg::CLOCK_MAX) ? clock_now + CB'(1) : clock_now;
  assign span_ext  = PW'(span_q);
  assign burst_ext = PW'(best_burst);
  assign wait_calc = (span_ext >= burst_ext) ? srt_pkg::sat16(32'(span_ext - burst_ext)) :
                                               16'd0;
  assign res_ran   = (op_q == srt_pkg::OP_TICK) && best_found;

  always_comb begin
    state_next = state;
    unique case (state)
      srt_pkg::S_IDLE: begin
        if (accept) begin
          state_next = (op == srt_pkg::OP_TICK) ? srt_pkg::S_SCAN : srt_pkg::S_RESULT;
        end
      end
      srt_pkg::S_SCAN: begin
        if (scan_cnt == SW'(srt_pkg::SLOTS - 1)) begin
          state_next = srt_pkg::S_SCAN_END;
        end
      end
      srt_pkg::S_SCAN_END: state_next = srt_pkg::S_UPDATE;
      srt_pkg::S_UPDATE:   state_next = srt_pkg::S_SPAN;
      srt_pkg::S_SPAN:     state_next = srt_pkg::S_RESULT;
      srt_pkg::S_RESULT: begin
        if (!out_valid || out_ready) begin
          state_next = srt_pkg::S_IDLE;
        end
      end
      default: state_next = srt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = load_idx;
    mem_wdata = '{arrival: CB'(arrival), burst: burst_in, remaining: burst_in};
    out_load  = 1'b0;
    unique case (state)
      srt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        mem_we   = load_hit;
      end
      srt_pkg::S_SCAN: mem_re = 1'b1;
      srt_pkg::S_UPDATE: begin
        mem_we    = best_found;
        mem_waddr = best_idx;
        mem_wdata = '{arrival: best_arr, burst: best_burst, remaining: rem_dec};
      end
      srt_pkg::S_RESULT: out_load = !out_valid || out_ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= slot_mem[scan_cnt];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= srt_pkg::S_IDLE;
      slot_valid <= '0;
      slot_done  <= '0;
      clock_now  <= '0;
      eval_valid <= 1'b0;
      out_valid  <= 1'b0;
      best_found <= 1'b0;
      fin_q      <= 1'b0;
      scan_cnt   <= '0;
    end else begin
      state      <= state_next;
      eval_valid <= mem_re;
      if (accept) begin
        best_found <= 1'b0;
        fin_q      <= 1'b0;
        scan_cnt   <= '0;
        if (op == srt_pkg::OP_CLEAR) begin
          slot_valid <= '0;
          slot_done  <= '0;
          clock_now  <= '0;
        end
      end
      if (load_hit) begin
        slot_valid[load_idx] <= 1'b1;
        slot_done[load_idx]  <= (burst_in == '0);
      end
      if (mem_re) begin
        scan_cnt <= scan_cnt + SW'(1);
      end
      if (eval_take) begin
        best_found <= 1'b1;
      end
      if (state == srt_pkg::S_UPDATE) begin
        clock_now <= clock_inc;
        if (best_found && (rem_dec == '0)) begin
          slot_done[best_idx] <= 1'b1;
          fin_q               <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q <= op;
    end
    if (mem_re) begin
      eval_idx <= scan_cnt;
    end
    if (eval_take) begin
      best_idx   <= eval_idx;
      best_arr   <= rd_data.arrival;
      best_burst <= rd_data.burst;
      best_rem   <= rd_data.remaining;
    end
    if (state == srt_pkg::S_SPAN) begin
      span_q <= clock_now - best_arr;
    end
    if (out_load) begin
      ran          <= res_ran;
      run_slot     <= res_ran ? 4'(best_idx) : 4'd0;
      finished     <= res_ran && fin_q;
      wait_span    <= (res_ran && fin_q) ? wait_calc : 16'd0;
      turnaround   <= (res_ran && fin_q) ? srt_pkg::sat16(32'(span_q)) : 16'd0;
      all_finished <= ~|(slot_valid & ~slot_done);
      elapsed      <= srt_pkg::sat16(32'(clock_now));
    end
  end

endmodule

@@ verif/tb_shortest_remaining_time_scheduler.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_shortest_remaining_time_scheduler: self-checking bench for the SRTF scheduler
// A short stimulus table covers the extremes, every opcode, ties, preemption,
// reloads and zero bursts. Random load/tick episodes follow under three
// idling profiles and a long receiver stall. Every result beat is checked
// against its row's stated result or a behavioral slot-table model kept in step.
// ----------------------------------------------------------------------------
module tb_shortest_remaining_time_scheduler;

  localparam logic [1:0] OP_RSVD = 2'd3;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic        ran;
    logic [3:0]  run_slot;
    logic        finished;
    logic [15:0] wait_span;
    logic [15:0] turnaround;
    logic        all_finished;
    logic [15:0] elapsed;
  } sched_result_t;

  typedef struct packed {
    logic [1:0]    op;
    logic [3:0]    slot;
    logic [15:0]   arrival;
    logic [11:0]   burst;
    logic          typed;
    sched_result_t want;
  } sched_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  op = srt_pkg::OP_LOAD;
  logic [3:0]  slot = '0;
  logic [15:0] arrival = '0;
  logic [11:0] burst = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        ran;
  logic [3:0]  run_slot;
  logic        finished;
  logic [15:0] wait_span;
  logic [15:0] turnaround;
  logic        all_finished;
  logic [15:0] elapsed;

  shortest_remaining_time_scheduler DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .slot(slot), .arrival(arrival), .burst(burst),
    .out_valid(out_valid), .out_ready(out_ready),
    .ran(ran), .run_slot(run_slot), .finished(finished),
    .wait_span(wait_span), .turnaround(turnaround),
    .all_finished(all_finished), .elapsed(elapsed)
  );

  always #1 clk = ~clk;

  // Shadow copy of the scheduler state.
  logic [15:0] now_clock;
  bit          tbl_valid [16];
  bit          tbl_done [16];
  logic [15:0] tbl_arrival [16];
  logic [11:0] tbl_burst [16];
  logic [11:0] tbl_left [16];

  sched_result_t pending_results[$];
  sched_item_t   directed_rows[$];
  int  items_sent = 0;
  int  in_idle_pct = 18;
  int  out_idle_pct = 70;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  quiet_cycles = 0;
  bit  failed = 1'b0;

  function automatic void wipe_table();
    now_clock = '0;
    for (int k = 0; k < 16; k++) begin
      tbl_valid[k] = 1'b0;
      tbl_done[k] = 1'b0;
    end
  endfunction

  function automatic sched_result_t schedule_step(sched_item_t it);
    sched_result_t r;
    bit            found;
    int            best;
    logic [15:0]   span;
    r = '0;
    found = 1'b0;
    best = 0;
    case (it.op)
      srt_pkg::OP_LOAD: begin
        tbl_valid[it.slot] = 1'b1;
        tbl_arrival[it.slot] = it.arrival;
        tbl_burst[it.slot] = it.burst;
        tbl_left[it.slot] = it.burst;
        tbl_done[it.slot] = (it.burst == 0);
      end
      srt_pkg::OP_TICK: begin
        for (int k = 0; k < 16; k++) begin
          if (tbl_valid[k] && !tbl_done[k] && tbl_arrival[k] <= now_clock) begin
            if (!found || tbl_left[k] < tbl_left[best]) begin
              found = 1'b1;
              best = k;
            end
          end
        end
        if (now_clock != srt_pkg::CLOCK_MAX) now_clock = now_clock + 1'b1;
        if (found) begin
          r.ran = 1'b1;
          r.run_slot = best[3:0];
          tbl_left[best] = tbl_left[best] - 1'b1;
          if (tbl_left[best] == 0) begin
            span = now_clock - tbl_arrival[best];
            tbl_done[best] = 1'b1;
            r.finished = 1'b1;
            r.turnaround = span;
            r.wait_span = (span >= tbl_burst[best]) ? span - tbl_burst[best] : 16'd0;
          end
        end
      end
      srt_pkg::OP_CLEAR: wipe_table();
      default: ;
    endcase
    r.all_finished = 1'b1;
    for (int k = 0; k < 16; k++)
      if (tbl_valid[k] && !tbl_done[k]) r.all_finished = 1'b0;
    r.elapsed = now_clock;
    return r;
  endfunction

  function automatic sched_item_t mk_item(logic [1:0] o, logic [3:0] s, logic [15:0] a,
                                          logic [11:0] b);
    sched_item_t it;
    it = '0;
    it.op = o;
    it.slot = s;
    it.arrival = a;
    it.burst = b;
    return it;
  endfunction

  function automatic sched_item_t with_result(sched_item_t it, logic r_ran, logic [3:0] r_slot,
                                              logic r_fin, logic [15:0] r_wait,
                                              logic [15:0] r_turn, logic r_all,
                                              logic [15:0] r_el);
    it.typed = 1'b1;
    it.want = {r_ran, r_slot, r_fin, r_wait, r_turn, r_all, r_el};
    return it;
  endfunction

  function automatic logic [15:0] pick_arrival();
    int unsigned a;
    if ($urandom_range(99) < 15) return 16'($urandom);
    a = now_clock + $urandom_range(0, 6);
    return (a > 32'hFFFF) ? 16'hFFFF : a[15:0];
  endfunction

  function automatic logic [11:0] pick_burst();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) return 12'd0;
    if (r < 8) return 12'hFFF;
    if (r < 28) return 12'($urandom_range(1, 4095));
    return 12'($urandom_range(1, 6));
  endfunction

  task automatic send_beat(sched_item_t it);
    sched_result_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= it.op;
    slot <= it.slot;
    arrival <= it.arrival;
    burst <= it.burst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = schedule_step(it);
    pending_results.push_back(it.typed ? it.want : predicted);
    items_sent++;
  endtask

  task automatic run_episode();
    int n_load;
    int n_tick;
    int r;
    if ($urandom_range(3) == 0)
      send_beat(mk_item(srt_pkg::OP_CLEAR, 4'($urandom), 16'($urandom), 12'($urandom)));
    n_load = $urandom_range(1, 6);
    repeat (n_load)
      send_beat(mk_item(srt_pkg::OP_LOAD, 4'($urandom), pick_arrival(), pick_burst()));
    n_tick = $urandom_range(4, 30);
    repeat (n_tick) begin
      r = $urandom_range(99);
      if (r < 8)
        send_beat(mk_item(srt_pkg::OP_LOAD, 4'($urandom), pick_arrival(), pick_burst()));
      else if (r < 11)
        send_beat(mk_item(OP_RSVD, 4'($urandom), 16'($urandom), 12'($urandom)));
      else
        send_beat(mk_item(srt_pkg::OP_TICK, 4'($urandom), 16'($urandom), 12'($urandom)));
    end
  endtask

  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    sched_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with none expected, expected none, actual elapsed %0d",
                 $time, elapsed);
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        compare_field("ran", 16'(want.ran), 16'(ran));
        compare_field("run_slot", 16'(want.run_slot), 16'(run_slot));
        compare_field("finished", 16'(want.finished), 16'(finished));
        compare_field("wait_span", want.wait_span, wait_span);
        compare_field("turnaround", want.turnaround, turnaround);
        compare_field("all_finished", 16'(want.all_finished), 16'(all_finished));
        compare_field("elapsed", want.elapsed, elapsed);
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (!hold_done && items_sent >= 100) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("[shortest_remaining_time_scheduler] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    wipe_table();
    directed_rows.push_back(with_result(mk_item(srt_pkg::OP_TICK, 4'd0, 16'd0, 12'd0),
                                        1'b0, 4'd0, 1'b0, 16'd0, 16'd0, 1'b1, 16'd1));
    directed_rows.push_back(with_result(mk_item(OP_RSVD, 4'hF, 16'hFFFF, 12'hFFF),
                                        1'b0, 4'd0, 1'b0, 16'd0, 16'd0, 1'b1, 16'd1));
    directed_rows.push_back(with_result(mk_item(srt_pkg::OP_CLEAR, 4'd0, 16'd0, 12'd0),
                                        1'b0, 4'd0, 1'b0, 16'd0, 16'd0, 1'b1, 16'd0));
    directed_rows.push_back(with_result(mk_item(srt_pkg::OP_LOAD, 4'd15, 16'hFFFF, 12'hFFF),
                                        1'b0, 4'd0, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0));
    directed_rows.push_back(mk_item(srt_pkg::OP_LOAD, 4'd0, 16'd0, 12'd1));
    directed_rows.push_back(mk_item(srt_pkg::OP_LOAD, 4'd3, 16'd0, 12'd0));
    directed_rows.push_back(with_result(mk_item(srt_pkg::OP_TICK, 4'd0, 16'd0, 12'd0),
                                        1'b1, 4'd0, 1'b1, 16'd0, 16'd1, 1'b0, 16'd1));
    directed_rows.push_back(mk_item(srt_pkg::OP_LOAD, 4'd1, 16'd1, 12'd3));
    directed_rows.push_back(mk_item(srt_pkg::OP_LOAD, 4'd2, 16'd1, 12'd3));
    directed_rows.push_back(mk_item(srt_pkg::OP_TICK, 4'd0, 16'd0, 12'd0));
    directed_rows.push_back(mk_item(srt_pkg::OP_LOAD, 4'd4, 16'd2, 12'd1));
    directed_rows.push_back(mk_item(srt_pkg::OP_TICK, 4'd0, 16'd0, 12'd0));
    directed_rows.push_back(mk_item(srt_pkg::OP_TICK, 4'd0, 16'd0, 12'd0));
    directed_rows.push_back(mk_item(srt_pkg::OP_LOAD, 4'd1, 16'd0, 12'd2));
    directed_rows.push_back(mk_item(srt_pkg::OP_TICK, 4'd0, 16'd0, 12'd0));
    directed_rows.push_back(mk_item(srt_pkg::OP_TICK, 4'd0, 16'd0, 12'd0));
    directed_rows.push_back(mk_item(srt_pkg::OP_LOAD, 4'd0, 16'd3, 12'hFFF));
    directed_rows.push_back(mk_item(srt_pkg::OP_LOAD, 4'd7, 16'hAAAA, 12'hAAA));
    directed_rows.push_back(mk_item(srt_pkg::OP_LOAD, 4'd10, 16'h5555, 12'h555));
    directed_rows.push_back(mk_item(srt_pkg::OP_TICK, 4'd0, 16'd0, 12'd0));
    directed_rows.push_back(mk_item(OP_RSVD, 4'd0, 16'd0, 12'd0));
    directed_rows.push_back(mk_item(srt_pkg::OP_CLEAR, 4'hF, 16'hFFFF, 12'hFFF));
    directed_rows.push_back(with_result(mk_item(srt_pkg::OP_TICK, 4'd0, 16'd0, 12'd0),
                                        1'b0, 4'd0, 1'b0, 16'd0, 16'd0, 1'b1, 16'd1));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) send_beat(directed_rows[i]);

    while (items_sent < 200) run_episode();
    in_idle_pct = 70;
    out_idle_pct = 18;
    while (items_sent < 400) run_episode();
    in_idle_pct = 0;
    out_idle_pct = 0;
    while (items_sent < 590) run_episode();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("[shortest_remaining_time_scheduler] OK");
    end else begin
      $display("[shortest_remaining_time_scheduler] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/srt_pkg.sv
rtl/shortest_remaining_time_scheduler.sv
verif/tb_shortest_remaining_time_scheduler.sv
